FILE: sv/hkd_pkg.sv
// Shared constants, register codes and interface types of the heatmap keypoint decoder.
`default_nettype none

package hkd_pkg;

  // Default values of the top-level parameters.
  localparam int KEYPOINT_COUNT_DEF = 17;
  localparam int MAX_MAP_CELLS_DEF  = 4096;
  localparam int SCORE_BITS_DEF     = 16;

  // Fixed field widths.
  localparam int KP_W       = 5;
  localparam int NET_W      = 11;
  localparam int SRC_W      = 14;
  localparam int COL_W      = NET_W - 2;
  localparam int POS_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Register reset values.
  localparam logic [NET_W-1:0] NET_WIDTH_RST   = NET_W'(192);
  localparam logic [NET_W-1:0] NET_HEIGHT_RST  = NET_W'(256);
  localparam logic [SRC_W-1:0] SOURCE_COLS_RST = SRC_W'(192);
  localparam logic [SRC_W-1:0] SOURCE_ROWS_RST = SRC_W'(256);
  localparam logic [NET_W-1:0] NET_DIM_MIN     = NET_W'(4);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NET_WIDTH   = 2'd0,
    CFG_NET_HEIGHT  = 2'd1,
    CFG_SOURCE_COLS = 2'd2,
    CFG_SOURCE_ROWS = 2'd3
  } cfg_reg_t;

  // Map geometry and rescale ratio derived from the configuration.
  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [SRC_W-1:0] num;
    logic [NET_W-1:0] den;
  } geom_t;

  // Status of the end-of-map refinement unit.
  typedef struct packed {
    logic busy;
    logic res_valid;
  } refine_status_t;

endpackage

`default_nettype wire

FILE: sv/hkd_divider.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
`default_nettype none

module hkd_divider #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8,
  localparam int STEP_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= STEP_W'(NUM_W);
      end else if (active) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // The partial remainder always stays below a nonzero divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: sv/hkd_geometry.sv
// Configuration registers and the derived map geometry and rescale ratio.
`default_nettype none

module hkd_geometry import hkd_pkg::*; #(
  parameter int MAX_MAP_CELLS = MAX_MAP_CELLS_DEF,
  localparam int CELLS_W = $clog2(MAX_MAP_CELLS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                 geom,
  output logic [CELLS_W-1:0]    cells,
  output logic                  geom_ready
);

  localparam int COL_LIM = (MAX_MAP_CELLS < (1 << COL_W) - 1) ? MAX_MAP_CELLS
                                                               : (1 << COL_W) - 1;
  localparam int CMP_W   = (CELLS_W > COL_W) ? CELLS_W : COL_W;
  localparam int CROSS_W = SRC_W + NET_W;

  typedef enum logic [2:0] {
    G_START,
    G_DIV,
    G_MUL,
    G_CROSS,
    G_SEL,
    G_DONE
  } geom_state_t;

  geom_state_t          state;
  logic [NET_W-1:0]     net_width;
  logic [NET_W-1:0]     net_height;
  logic [SRC_W-1:0]     source_cols;
  logic [SRC_W-1:0]     source_rows;
  logic [NET_W-1:0]     w_eff;
  logic [NET_W-1:0]     h_eff;
  logic [COL_W-1:0]     cols0;
  logic [COL_W-1:0]     rows0;
  logic [COL_W-1:0]     cols_c;
  logic [COL_W-1:0]     rows;
  logic [2*COL_W-1:0]   cell_prod;
  logic [CROSS_W-1:0]   cross_a;
  logic [CROSS_W-1:0]   cross_b;
  logic                 cfg_wr;
  logic                 div_start;
  logic                 div_done;
  logic [CELLS_W-1:0]   div_quo;
  logic [COL_W-1:0]     div_rem;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_width   <= NET_WIDTH_RST;
      net_height  <= NET_HEIGHT_RST;
      source_cols <= SOURCE_COLS_RST;
      source_rows <= SOURCE_ROWS_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NET_WIDTH:   net_width   <= cfg_data[NET_W-1:0];
        CFG_NET_HEIGHT:  net_height  <= cfg_data[NET_W-1:0];
        CFG_SOURCE_COLS: source_cols <= cfg_data[SRC_W-1:0];
        CFG_SOURCE_ROWS: source_rows <= cfg_data[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff     = (net_width < NET_DIM_MIN) ? NET_DIM_MIN : net_width;
    h_eff     = (net_height < NET_DIM_MIN) ? NET_DIM_MIN : net_height;
    cols0     = w_eff[NET_W-1:2];
    rows0     = h_eff[NET_W-1:2];
    cols_c    = (cols0 > COL_W'(COL_LIM)) ? COL_W'(COL_LIM) : cols0;
    cell_prod = cols_c * rows;
    div_start = (state == G_START);
  end

  // Row limit is the number of whole rows of this width that fit in the store.
  hkd_divider #(
    .NUM_W (CELLS_W),
    .DEN_W (COL_W)
  ) u_row_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (CELLS_W'(MAX_MAP_CELLS)),
    .divisor   (cols_c),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= G_START;
      geom_ready <= 1'b0;
    end else if (cfg_wr) begin
      state      <= G_START;
      geom_ready <= 1'b0;
    end else begin
      case (state)
        G_START: state <= G_DIV;
        G_DIV: begin
          if (div_done) begin
            rows  <= (CMP_W'(div_quo) < CMP_W'(rows0)) ? COL_W'(div_quo) : rows0;
            state <= G_MUL;
          end
        end
        G_MUL: begin
          cells   <= CELLS_W'(cell_prod);
          cross_a <= source_cols * h_eff;
          state   <= G_CROSS;
        end
        G_CROSS: begin
          cross_b <= source_rows * w_eff;
          state   <= G_SEL;
        end
        G_SEL: begin
          geom.cols <= cols_c;
          if (cross_a >= cross_b) begin
            geom.num <= source_cols;
            geom.den <= w_eff;
          end else begin
            geom.num <= source_rows;
            geom.den <= h_eff;
          end
          geom_ready <= 1'b1;
          state      <= G_DONE;
        end
        G_DONE: ;
        default: state <= G_START;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/hkd_peak_refine.sv
// Map store and the end-of-map sequencer that refines and rescales the peak.
`default_nettype none

module hkd_peak_refine import hkd_pkg::*; #(
  parameter int MAX_MAP_CELLS = MAX_MAP_CELLS_DEF,
  parameter int SCORE_BITS    = SCORE_BITS_DEF,
  localparam int CNT_W   = $clog2(MAX_MAP_CELLS),
  localparam int CELLS_W = $clog2(MAX_MAP_CELLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [CNT_W-1:0]             wr_addr,
  input  logic signed [SCORE_BITS-1:0] wr_data,
  input  logic                         start,
  input  logic [CNT_W-1:0]             best_cell,
  input  logic [CELLS_W-1:0]           filled,
  input  geom_t                        geom,
  input  logic                         res_take,
  output refine_status_t               status,
  output logic [POS_W-1:0]             pos_x,
  output logic [POS_W-1:0]             pos_y
);

  localparam int QW     = CNT_W + 2;
  localparam int PROD_W = QW + SRC_W;
  localparam int SUM_W  = ((CELLS_W > COL_W) ? CELLS_W : COL_W) + 1;

  typedef enum logic [3:0] {
    R_IDLE,
    R_LOC,
    R_RDX,
    R_RDY,
    R_GY,
    R_SCX,
    R_WX,
    R_SCY,
    R_WY,
    R_HOLD
  } refine_state_t;

  refine_state_t          state;
  logic [SCORE_BITS-1:0]  mem [MAX_MAP_CELLS];
  logic [SCORE_BITS-1:0]  rd_a;
  logic [SCORE_BITS-1:0]  rd_b;
  logic [CNT_W-1:0]       rd_addr_a;
  logic [CNT_W-1:0]       rd_addr_b;
  logic [CNT_W-1:0]       peak_idx;
  logic [CELLS_W-1:0]     filled_r;
  logic [CNT_W-1:0]       cx;
  logic [CNT_W-1:0]       cy;
  logic                   gx;
  logic                   gy;
  logic                   x_lo_in;
  logic                   x_hi_in;
  logic                   y_lo_in;
  logic                   y_hi_in;
  logic [QW-1:0]          qx;
  logic [QW-1:0]          qy;
  logic [QW-1:0]          q_sel;
  logic [PROD_W-1:0]      mul;
  logic [PROD_W-1:0]      prod;
  logic                   div_start;
  logic [PROD_W-1:0]      div_num;
  logic [NET_W-1:0]       div_den;
  logic                   div_done;
  logic [PROD_W-1:0]      div_quo;
  logic [NET_W-1:0]       div_rem;
  logic [POS_W-1:0]       pos_sat;

  // True when the upper neighbor counts as larger than the lower one; a
  // neighbor outside the map loses to any score.
  function automatic logic upper_wins(input logic a_in, input logic b_in,
                                      input logic signed [SCORE_BITS-1:0] a,
                                      input logic signed [SCORE_BITS-1:0] b);
    logic res;
    if (!b_in) begin
      res = 1'b0;
    end else if (!a_in) begin
      res = 1'b1;
    end else begin
      res = b > a;
    end
    return res;
  endfunction

  function automatic logic [QW-1:0] quarter_pos(input logic [CNT_W-1:0] c,
                                                input logic g);
    logic [QW-1:0] base;
    base = {c, 2'b00};
    if (g) begin
      quarter_pos = base + QW'(1);
    end else if (c == '0) begin
      quarter_pos = '0;
    end else begin
      quarter_pos = base - QW'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_comb begin
    case (state)
      R_RDX: begin
        rd_addr_a = peak_idx - CNT_W'(1);
        rd_addr_b = peak_idx + CNT_W'(1);
      end
      R_RDY: begin
        rd_addr_a = peak_idx - CNT_W'(geom.cols);
        rd_addr_b = peak_idx + CNT_W'(geom.cols);
      end
      default: begin
        rd_addr_a = '0;
        rd_addr_b = '0;
      end
    endcase

    x_lo_in = (cx != '0);
    x_hi_in = (SUM_W'(cx) + SUM_W'(1) < SUM_W'(geom.cols)) &&
              (SUM_W'(peak_idx) + SUM_W'(1) < SUM_W'(filled_r));
    y_lo_in = (cy != '0);
    y_hi_in = (SUM_W'(peak_idx) + SUM_W'(geom.cols) < SUM_W'(filled_r));

    qx    = quarter_pos(cx, gx);
    qy    = quarter_pos(cy, gy);
    q_sel = (state == R_GY) ? qx : qy;
    mul   = q_sel * geom.num;

    div_start = (state == R_IDLE && start) || state == R_SCX || state == R_SCY;
    div_num   = (state == R_IDLE) ? PROD_W'(best_cell) : prod;
    div_den   = (state == R_IDLE || state == R_LOC) ? NET_W'(geom.cols) : geom.den;
    pos_sat   = (div_quo > PROD_W'(POS_MAX)) ? POS_MAX : POS_W'(div_quo);

    status.busy      = (state != R_IDLE);
    status.res_valid = (state == R_HOLD);
  end

  // One divider serves the peak cell's row and column and both rescales.
  hkd_divider #(
    .NUM_W (PROD_W),
    .DEN_W (NET_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            peak_idx <= best_cell;
            filled_r <= filled;
            state    <= R_LOC;
          end
        end
        R_LOC: begin
          if (div_done) begin
            cx    <= CNT_W'(div_rem);
            cy    <= CNT_W'(div_quo);
            state <= R_RDX;
          end
        end
        R_RDX: state <= R_RDY;
        R_RDY: begin
          gx    <= upper_wins(x_lo_in, x_hi_in, rd_a, rd_b);
          state <= R_GY;
        end
        R_GY: begin
          gy    <= upper_wins(y_lo_in, y_hi_in, rd_a, rd_b);
          prod  <= mul;
          state <= R_SCX;
        end
        R_SCX: state <= R_WX;
        R_WX: begin
          if (div_done) begin
            pos_x <= pos_sat;
            prod  <= mul;
            state <= R_SCY;
          end
        end
        R_SCY: state <= R_WY;
        R_WY: begin
          if (div_done) begin
            pos_y <= pos_sat;
            state <= R_HOLD;
          end
        end
        R_HOLD: begin
          if (res_take) begin
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == R_IDLE)
    else $error("map store written during refinement");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == R_IDLE)
    else $error("refinement started while busy");

  a_release_on_take: assert property (@(posedge clk) disable iff (rst)
    $fell(status.busy) |-> $past(res_take) && $past(state == R_HOLD))
    else $error("refinement left without its result being taken");

endmodule

`default_nettype wire

FILE: sv/heatmap_keypoint_decoder_unit.sv
// Top level: cell stream tracking, keypoint counting and the result register.
// Result path: after a map's last cell, the divider finds the peak's row and column,
//   the neighbours are read, x and y rescaled; the result loads when the output is free.
// Throughput: one cell per cycle inside a map; the input stalls until the result is taken,
//   the peak being refined by three passes through the shared one-bit-per-cycle divider.
// Reset: synchronous, active high; loads default registers, then a geometry pass stalls the
//   input while it divides, multiplies and picks the ratio; every register write repeats it.
`default_nettype none

module heatmap_keypoint_decoder_unit import hkd_pkg::*; #(
  parameter int KEYPOINT_COUNT = KEYPOINT_COUNT_DEF,
  parameter int MAX_MAP_CELLS  = MAX_MAP_CELLS_DEF,
  parameter int SCORE_BITS     = SCORE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         score_valid,
  output logic                         score_stall,
  input  logic signed [SCORE_BITS-1:0] score,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [KP_W-1:0]              keypoint_index,
  output logic signed [SCORE_BITS-1:0] peak_score,
  output logic [POS_W-1:0]             pos_x,
  output logic [POS_W-1:0]             pos_y,
  output logic                         last_keypoint
);

  localparam int CNT_W   = $clog2(MAX_MAP_CELLS);
  localparam int CELLS_W = $clog2(MAX_MAP_CELLS + 1);
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic [KP_W-1:0] KP_LAST = KP_W'(KEYPOINT_COUNT - 1);

  geom_t                        geom;
  logic [CELLS_W-1:0]           cells;
  logic                         geom_ready;
  refine_status_t               status;
  logic [POS_W-1:0]             ref_pos_x;
  logic [POS_W-1:0]             ref_pos_y;

  // Stream tracking state.
  logic [CNT_W-1:0]             cell_count;
  logic signed [SCORE_BITS-1:0] best_score;
  logic [CNT_W-1:0]             best_cell;
  logic [KP_W-1:0]              keypoint_counter;

  // Per-map values held while the peak is refined.
  logic signed [SCORE_BITS-1:0] pend_score;
  logic [KP_W-1:0]              pend_kp;
  logic                         pend_last;

  logic                         in_acc;
  logic [CELLS_W-1:0]           count_inc;
  logic                         new_best;
  logic                         map_end;
  logic [CNT_W-1:0]             best_cell_now;
  logic signed [SCORE_BITS-1:0] best_score_now;
  logic                         out_load;

  hkd_geometry #(
    .MAX_MAP_CELLS (MAX_MAP_CELLS)
  ) u_geometry (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .geom       (geom),
    .cells      (cells),
    .geom_ready (geom_ready)
  );

  // Cells are taken only when the geometry is settled and no peak is being
  // refined, so the store is never written while the sequencer reads it.
  assign score_stall = !geom_ready || status.busy;
  assign in_acc      = score_valid && !score_stall;

  // The first cell of a map always becomes the running best; later cells
  // replace it only when strictly larger, which keeps the first maximum.
  always_comb begin
    count_inc      = CELLS_W'(cell_count) + CELLS_W'(1);
    map_end        = in_acc && (count_inc >= cells);
    new_best       = (cell_count == '0) || (score > best_score);
    best_cell_now  = new_best ? cell_count : best_cell;
    best_score_now = new_best ? score : best_score;
    out_load       = status.res_valid && (!result_valid || !result_stall);
  end

  hkd_peak_refine #(
    .MAX_MAP_CELLS (MAX_MAP_CELLS),
    .SCORE_BITS    (SCORE_BITS)
  ) u_refine (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_acc),
    .wr_addr   (cell_count),
    .wr_data   (score),
    .start     (map_end),
    .best_cell (best_cell_now),
    .filled    (count_inc),
    .geom      (geom),
    .res_take  (out_load),
    .status    (status),
    .pos_x     (ref_pos_x),
    .pos_y     (ref_pos_y)
  );

  // A map ends as soon as the cell count reaches the current cell total,
  // even if the geometry shrank part way through the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count       <= '0;
      best_score       <= SCORE_MIN;
      best_cell        <= '0;
      keypoint_counter <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (in_acc) begin
        if (map_end) begin
          cell_count <= '0;
          best_score <= SCORE_MIN;
          best_cell  <= '0;
          if (keypoint_counter >= KP_LAST) begin
            keypoint_counter <= '0;
          end else begin
            keypoint_counter <= keypoint_counter + KP_W'(1);
          end
        end else begin
          cell_count <= CNT_W'(count_inc);
          best_score <= best_score_now;
          best_cell  <= best_cell_now;
        end
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers; the result register takes a beat whenever it is empty
  // or its current beat leaves in the same cycle.
  always_ff @(posedge clk) begin
    if (map_end) begin
      pend_score <= best_score_now;
      pend_kp    <= keypoint_counter;
      pend_last  <= (keypoint_counter >= KP_LAST);
    end
    if (out_load) begin
      keypoint_index <= pend_kp;
      peak_score     <= pend_score;
      pos_x          <= ref_pos_x;
      pos_y          <= ref_pos_y;
      last_keypoint  <= pend_last;
    end
  end

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    keypoint_counter <= KP_LAST)
    else $error("keypoint counter out of range");

  a_map_end_starts_refine: assert property (@(posedge clk) disable iff (rst)
    map_end |=> status.busy)
    else $error("map end did not start refinement");

  a_result_from_refine: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(status.res_valid))
    else $error("result beat without a refined peak");

endmodule

`default_nettype wire
